[sv/rtbd_pkg.sv]
// ----------------------------------------------------------------------------
// rtbd_pkg
// Shared types and constants of the RMS burst detector.
// ----------------------------------------------------------------------------
`default_nettype none
package rtbd_pkg;

  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned SampleWidth = 16;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_CALIB_LENGTH = 3'd0,
    CFG_TRIGGER_COUNT = 3'd1,
    CFG_PULSE_LENGTH = 3'd2,
    CFG_REFRACTORY = 3'd3,
    CFG_THRESHOLD_K = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_MEAN_DIV,
    ST_MEAN_UPD,
    ST_DEV_MUL,
    ST_SD_DIV,
    ST_SD_ROOT,
    ST_THRESH,
    ST_DECIDE,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

[sv/rms_threshold_burst_detector.sv]
// ----------------------------------------------------------------------------
// rms_threshold_burst_detector
// RMS of four samples, learned mean/deviation threshold, burst detection.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | sample_a..d, buffer_start
//  out     | out_valid/out_stall| pulse_start, pulse_end, pulse_level,
//          |                    | calibrating, rms_value
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
// While calibrating, a request runs two divides and two square roots on the
// shared divide/root unit, one bit per cycle; after calibration it runs one
// divide and two roots, and while no statistics exist only the RMS root.
// in_stall is high while an item is in work or its result waits; out_stall
// holds a waiting result in ST_OUT.
// Reset (rst, synchronous) restores register defaults and clears statistics.
`default_nettype none
module rms_threshold_burst_detector (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [rtbd_pkg::SampleWidth-1:0] sample_a,
  input  wire logic [rtbd_pkg::SampleWidth-1:0] sample_b,
  input  wire logic [rtbd_pkg::SampleWidth-1:0] sample_c,
  input  wire logic [rtbd_pkg::SampleWidth-1:0] sample_d,
  input  wire logic                    buffer_start,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         pulse_start,
  output logic                         pulse_end,
  output logic                         pulse_level,
  output logic                         calibrating,
  output logic [15:0]                  rms_value,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [rtbd_pkg::CfgIdxWidth-1:0] cfg_index,
  input  wire logic [15:0]             cfg_data
);
  import rtbd_pkg::*;

  localparam int SqW = 2 * SampleWidth;

  state_t state, state_next;
  logic [15:0] calib_length, trigger_count, pulse_length, refractory_items;
  logic [7:0]  threshold_k;
  logic [15:0] stat_count, above_count, since_detect, pulse_elapsed;
  logic [23:0] running_mean;
  logic [63:0] sq_dev_sum;
  logic        refractory_active, pulse_active;

  logic signed [SampleWidth-1:0] smp [4];
  logic        start_q;
  logic [1:0]  sidx;
  logic [63:0] acc;
  logic [15:0] rms;
  logic        calib;
  logic signed [25:0] delta;
  logic [35:0] thr_add;
  logic [63:0] sd;
  logic [36:0] thr;

  logic        u_start, u_sqrt, u_done;
  logic [63:0] u_num, u_den, u_res;

  rtbd_divsqrt u_unit (
    .clk(clk), .rst(rst), .start(u_start), .mode_sqrt(u_sqrt),
    .num(u_num), .den(u_den), .done(u_done), .result(u_res)
  );

  logic signed [SampleWidth-1:0] cur;
  logic [SampleWidth-1:0] mag;
  logic [SqW-1:0] sqv;
  logic [23:0] xq;
  logic signed [25:0] d2;
  logic signed [51:0] prod;
  logic [64:0] sum_sat;
  logic [63:0] sq_dev_sum_next;
  logic signed [25:0] stepv;
  logic [24:0] u_res_mean;

  assign cur = smp[sidx];
  assign mag = cur[SampleWidth-1] ? SampleWidth'(-cur) : cur;
  assign sqv = SqW'(mag) * SqW'(mag);
  assign xq = {rms, 8'd0};
  assign d2 = $signed({2'b00, xq}) - $signed({2'b00, running_mean});
  assign sum_sat = {1'b0, sq_dev_sum} + 65'(unsigned'(prod));
  assign sq_dev_sum_next = (calib && !prod[51] && prod != '0) ?
                           (sum_sat[64] ? '1 : sum_sat[63:0]) : sq_dev_sum;
  assign u_res_mean = u_res[24:0];
  assign stepv = delta[25] ? -$signed({1'b0, u_res_mean}) : $signed({1'b0, u_res_mean});
  assign thr = 37'(running_mean) + 37'(thr_add);

  assign in_stall = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    u_start = 1'b0;
    u_sqrt = 1'b0;
    u_num = acc;
    u_den = 64'd1;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SQUARE;
      ST_SQUARE: if (sidx == 2'd3) begin
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        u_sqrt = 1'b1;
        u_num = {2'b00, acc[63:2]};
        u_start = !u_done && !calib;
        if (u_done) state_next = ST_MEAN_DIV;
      end
      ST_MEAN_DIV: begin
        u_num = 64'(d2[25] ? -d2 : d2);
        u_den = 64'(stat_count);
        if (!calib) state_next = ST_DEV_MUL;
        else begin
          u_start = !u_done && acc[0];
          if (u_done) state_next = ST_MEAN_UPD;
        end
      end
      ST_MEAN_UPD: state_next = ST_DEV_MUL;
      ST_DEV_MUL: state_next = ST_SD_DIV;
      ST_SD_DIV: begin
        u_num = sq_dev_sum_next;
        u_den = {46'd0, stat_count, 2'b00};
        if (stat_count == 16'd0) state_next = ST_THRESH;
        else begin
          u_start = !u_done && acc[0];
          if (u_done) state_next = ST_SD_ROOT;
        end
      end
      ST_SD_ROOT: begin
        u_sqrt = 1'b1;
        u_num = sd;
        u_start = !u_done && acc[0];
        if (u_done) state_next = ST_THRESH;
      end
      ST_THRESH: state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_length <= 16'd15000;
      trigger_count <= 16'd150;
      pulse_length <= 16'd1000;
      refractory_items <= 16'd15000;
      threshold_k <= 8'd32;
      stat_count <= '0;
      running_mean <= '0;
      sq_dev_sum <= '0;
      above_count <= '0;
      refractory_active <= 1'b0;
      since_detect <= '0;
      pulse_active <= 1'b0;
      pulse_elapsed <= '0;
      calib <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CALIB_LENGTH: calib_length <= cfg_data;
          CFG_TRIGGER_COUNT: trigger_count <= cfg_data;
          CFG_PULSE_LENGTH: pulse_length <= cfg_data;
          CFG_REFRACTORY: refractory_items <= cfg_data;
          CFG_THRESHOLD_K: threshold_k <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (in_valid) begin
          smp[0] <= sample_a;
          smp[1] <= sample_b;
          smp[2] <= sample_c;
          smp[3] <= sample_d;
          start_q <= buffer_start;
          sidx <= 2'd0;
          acc <= '0;
          calib <= 1'b0;
        end
        ST_SQUARE: begin
          acc <= acc + 64'(sqv);
          sidx <= sidx + 2'd1;
        end
        ST_ROOT: if (u_done) begin
          rms <= u_res[15:0];
          calib <= (stat_count < calib_length);
          if (stat_count < calib_length) stat_count <= stat_count + 16'd1;
          acc <= 64'd1;
        end else if (!calib) begin
          calib <= 1'b1;
        end else begin
          calib <= 1'b1;
        end
        ST_MEAN_DIV: begin
          if (acc[0]) begin
            delta <= d2;
            acc[0] <= 1'b0;
          end
        end
        ST_MEAN_UPD: running_mean <= 24'(26'($signed({2'b00, running_mean}) + stepv));
        ST_DEV_MUL: begin
          if (calib) prod <= delta * d2;
          else prod <= '0;
          acc <= 64'd1;
        end
        ST_SD_DIV: begin
          if (acc[0]) begin
            sq_dev_sum <= sq_dev_sum_next;
            acc[0] <= 1'b0;
            sd <= '0;
          end else if (u_done) begin
            sd <= u_res;
            acc[0] <= 1'b1;
          end
        end
        ST_SD_ROOT: begin
          if (acc[0]) acc[0] <= 1'b0;
          else if (u_done) sd <= u_res;
        end
        ST_THRESH: thr_add <= 36'((40'(threshold_k) * 40'(sd[31:0])) >> 4);
        ST_DECIDE: begin
          logic above, refr, fired, ended, ra;
          logic [15:0] ac, sdc;
          above = {13'd0, xq} >= thr;
          refr = 1'b0;
          ra = refractory_active;
          sdc = since_detect;
          if (ra) begin
            if (sdc < refractory_items) begin
              refr = 1'b1;
              sdc = sdc + 16'd1;
            end else ra = 1'b0;
          end
          ac = above_count;
          if (above && !refr) begin
            if (ac != 16'hFFFF) ac = ac + 16'd1;
          end else if (!above && start_q) ac = '0;
          fired = !refr && (ac >= trigger_count);
          ended = 1'b0;
          if (fired) begin
            ac = '0;
            ra = 1'b1;
            sdc = '0;
          end
          above_count <= ac;
          refractory_active <= ra;
          since_detect <= sdc;
          if (fired || pulse_active) begin
            if ((fired ? 16'd0 : pulse_elapsed) >= pulse_length) begin
              ended = 1'b1;
              pulse_active <= 1'b0;
              pulse_elapsed <= fired ? 16'd0 : pulse_elapsed;
            end else begin
              pulse_active <= 1'b1;
              pulse_elapsed <= (fired ? 16'd0 : pulse_elapsed) + 16'd1;
            end
          end
          pulse_start <= fired;
          pulse_end <= ended;
          pulse_level <= (fired || pulse_active) && !ended;
          calibrating <= calib;
          rms_value <= rms;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/rtbd_divsqrt.sv]
// ----------------------------------------------------------------------------
// rtbd_divsqrt
// Shared iterative unit: 64-bit unsigned restoring divide or integer square
// root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rtbd_divsqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        mode_sqrt,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [63:0]      result
);

  logic [63:0] rem_q;
  logic [65:0] part;
  logic [63:0] quo;
  logic [63:0] dval;
  logic [6:0]  cnt;
  logic        busy;
  logic        sq;
  logic [65:0] trial;
  logic [65:0] shifted;

  always_comb begin
    if (sq) begin
      shifted = {part[63:0], rem_q[63:62]};
      trial = {quo, 2'b01};
    end else begin
      shifted = {part[64:0], rem_q[63]};
      trial = {2'b00, dval};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        sq <= mode_sqrt;
        rem_q <= num;
        part <= '0;
        quo <= '0;
        dval <= den;
        cnt <= mode_sqrt ? 7'd32 : 7'd64;
      end else if (busy) begin
        if (sq) rem_q <= {rem_q[61:0], 2'b00};
        else rem_q <= {rem_q[62:0], 1'b0};
        if (shifted >= trial) begin
          part <= shifted - trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          part <= shifted;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = quo;

endmodule
`default_nettype wire
